// ----- design/hotspot_lfu_set_assoc_cache_assert.svh -----
// Assertion macros shared by the hotness cache modules.
`ifndef HOTSPOT_LFU_SET_ASSOC_CACHE_ASSERT_SVH
`define HOTSPOT_LFU_SET_ASSOC_CACHE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HLFU_ASSERT_IMP(label, ck, rstn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hlfu assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HLFU_ASSERT_NXT(label, ck, rstn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hlfu assertion failed");

`endif

// ----- design/hlfu_pkg.sv -----
`default_nettype none

package hlfu_pkg;

    localparam int SET_BITS    = 10;
    localparam int TAG_BITS    = 10;
    localparam int OFFSET_BITS = 4;
    localparam int WAYS        = 4;

    localparam int SETS      = 1 << SET_BITS;
    localparam int WAY_IDX_W = $clog2(WAYS);
    localparam int CNT_W     = 16;
    localparam int SUM_W     = CNT_W + $clog2(WAYS);
    localparam int WAY_ROW_W = CNT_W + TAG_BITS;
    localparam int ROW_W     = WAYS * WAY_ROW_W;

    localparam int ADDR_W  = 32;
    localparam int TRIG_W  = 16;
    localparam int AGE_W   = 14;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    typedef logic [SET_BITS-1:0]  set_t;
    typedef logic [TAG_BITS-1:0]  tag_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [WAY_IDX_W-1:0] way_t;
    typedef logic [SUM_W-1:0]     sum_t;

    localparam cnt_t COUNT_MAX = '1;
    localparam cnt_t COUNT_ONE = cnt_t'(1);

    localparam logic [TRIG_W-1:0] TRIG_RESET = TRIG_W'(128);
    localparam logic [AGE_W-1:0]  AGE_RESET  = AGE_W'(256);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_AGING   = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic clear;   // write one zero row of the clearing pass
        logic load;    // latch address, issue set read
        logic lookup;  // tag compare, increment, set sum
        logic age;     // apply aging if the set average is too high
        logic pick;    // choose the way to report or fill
        logic commit;  // write the set back, load the result
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic out_busy;
    } stat_t;

    function automatic cnt_t sat_inc(input cnt_t c);
        cnt_t r;
        r = (c == COUNT_MAX) ? c : c + COUNT_ONE;
        return r;
    endfunction

    // ceil(c/2)
    function automatic cnt_t halve_up(input cnt_t c);
        logic [CNT_W:0] s;
        s = {1'b0, c} + {{CNT_W{1'b0}}, 1'b1};
        return s[CNT_W:1];
    endfunction

endpackage

`default_nettype wire

// ----- design/hotspot_lfu_set_assoc_cache.sv -----
`default_nettype none

// Channel     Direction  Handshake              Payload
// ---------   ---------  ---------------------  ------------------------------------------
// input       in         in_valid / in_ready    target_address
// result      out        out_valid / out_ready  hit, way_used, entry_count, hot, replaced
// config      in         cfg_write_en           cfg_index, cfg_data
//
// Each transaction goes through set read, lookup/increment, aging, way selection and
// write-back before the next one is accepted; the set memory's read-modify-write is why.
// After reset the block clears the counts of all 1024 set rows, one set row per cycle;
// in_ready stays low meanwhile, configuration writes are taken.
// A finished result sits in an output register; a new transaction is accepted while it
// waits, and write-back of the following one holds until the result is taken.

module hotspot_lfu_set_assoc_cache (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [hlfu_pkg::ADDR_W-1:0]     target_address,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 hit,
    output logic [1:0]                           way_used,
    output logic [15:0]                          entry_count,
    output logic                                 hot,
    output logic                                 replaced,
    input  wire logic                            cfg_write_en,
    input  wire logic [hlfu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hlfu_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hlfu_pkg::*;

    // Command and status between the sequencer and the set datapath
    cmd_t  cmd;
    stat_t stat;

    // Sequencer: clearing pass, then one transaction at a time through the steps
    hlfu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: set memory, count update, aging, victim choice, result register
    hlfu_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .target_address (target_address),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .hit            (hit),
        .way_used       (way_used),
        .entry_count    (entry_count),
        .hot            (hot),
        .replaced       (replaced)
    );

endmodule

`default_nettype wire

// ----- design/hlfu_ctrl.sv -----
`default_nettype none

module hlfu_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire hlfu_pkg::stat_t stat,
    output hlfu_pkg::cmd_t       cmd
);
    import hlfu_pkg::*;

    `include "hotspot_lfu_set_assoc_cache_assert.svh"

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_LOOKUP = 6'b000100,
        S_AGE    = 6'b001000,
        S_PICK   = 6'b010000,
        S_FILL   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = S_AGE;
            end
            S_AGE:
            begin
                cmd.age    = 1'b1;
                state_next = S_PICK;
            end
            S_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = S_FILL;
            end
            S_FILL:
            begin
                // hold until the result register is free
                if (!stat.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `HLFU_ASSERT_NXT(a_accept_to_lookup, clk, rst_n, in_valid && in_ready,
                     state_reg == S_LOOKUP)
    `HLFU_ASSERT_NXT(a_clear_exit, clk, rst_n, state_reg == S_CLEAR && stat.clear_last,
                     state_reg == S_IDLE)
    `HLFU_ASSERT_IMP(a_state_onehot, clk, rst_n, 1'b1, $onehot(state_reg))

endmodule

`default_nettype wire

// ----- design/hlfu_dpath.sv -----
`default_nettype none

module hlfu_dpath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire hlfu_pkg::cmd_t                  cmd,
    output hlfu_pkg::stat_t                      stat,
    input  wire logic [hlfu_pkg::ADDR_W-1:0]     target_address,
    input  wire logic                            cfg_write_en,
    input  wire logic [hlfu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hlfu_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            out_ready,
    output logic                                 out_valid,
    output logic                                 hit,
    output logic [1:0]                           way_used,
    output logic [15:0]                          entry_count,
    output logic                                 hot,
    output logic                                 replaced
);
    import hlfu_pkg::*;

    `include "hotspot_lfu_set_assoc_cache_assert.svh"

    // Set store: one row per set, each way {tag, count}
    logic [ROW_W-1:0] mem [SETS];
    logic [ROW_W-1:0] rd_data_reg;

    logic [TRIG_W-1:0] trig_reg;
    logic [AGE_W-1:0]  age_lim_reg;

    set_t clr_idx_reg;
    set_t set_reg;
    tag_t tag_reg;

    cnt_t cnt_reg [WAYS];
    cnt_t cnt_next [WAYS];
    logic hit_reg;
    logic hit_next;
    way_t hit_way_reg;
    way_t hit_way_next;
    sum_t sum_reg;
    sum_t sum_next;

    way_t used_reg;
    way_t used_next;
    logic repl_reg;
    logic repl_next;

    logic out_valid_reg;
    logic out_hit_reg;
    way_t out_way_reg;
    cnt_t out_cnt_reg;
    logic out_hot_reg;
    logic out_repl_reg;

    sum_t             age_bound;
    logic             age_do;
    cnt_t             entry_next;
    logic [ROW_W-1:0] wr_row;
    logic             wr_en;
    set_t             wr_addr;
    logic [ROW_W-1:0] wr_data;

    assign stat.clear_last = (clr_idx_reg == set_t'(SETS - 1));
    assign stat.out_busy   = out_valid_reg && !out_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_reg    <= TRIG_RESET;
            age_lim_reg <= AGE_RESET;
        end
        else if (cfg_write_en)
        begin
            if (cfg_index == CFG_TRIGGER)
            begin
                trig_reg <= cfg_data[TRIG_W-1:0];
            end
            if (cfg_index == CFG_AGING)
            begin
                age_lim_reg <= cfg_data[AGE_W-1:0];
            end
        end
    end

    // Clearing pass index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_idx_reg <= clr_idx_reg + set_t'(1);
        end
    end

    // Memory port
    assign wr_en   = cmd.clear || cmd.commit;
    assign wr_addr = cmd.clear ? clr_idx_reg : set_reg;
    assign wr_data = cmd.clear ? '0 : wr_row;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.load)
        begin
            rd_data_reg <= mem[target_address[OFFSET_BITS +: SET_BITS]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            set_reg <= target_address[OFFSET_BITS +: SET_BITS];
            tag_reg <= target_address[OFFSET_BITS + SET_BITS +: TAG_BITS];
        end
    end

    // Lookup: compare tags, bump matching ways, sum the set
    always_comb
    begin
        cnt_t c;
        tag_t t;
        hit_next     = 1'b0;
        hit_way_next = '0;
        sum_next     = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            c = rd_data_reg[w*WAY_ROW_W +: CNT_W];
            t = rd_data_reg[w*WAY_ROW_W + CNT_W +: TAG_BITS];
            cnt_next[w] = c;
            if (c != '0 && t == tag_reg)
            begin
                hit_next     = 1'b1;
                hit_way_next = way_t'(w);
                cnt_next[w]  = sat_inc(c);
            end
            sum_next = sum_next + sum_t'(cnt_next[w]);
        end
    end

    // floor(sum / WAYS) > limit  <=>  sum >= (limit + 1) * WAYS
    assign age_bound = SUM_W'((sum_t'(age_lim_reg) + sum_t'(1)) * sum_t'(WAYS));
    assign age_do    = (sum_reg >= age_bound);

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            hit_reg     <= hit_next;
            hit_way_reg <= hit_way_next;
            sum_reg     <= sum_next;
        end
        for (int w = 0; w < WAYS; w++)
        begin
            if (cmd.lookup)
            begin
                cnt_reg[w] <= cnt_next[w];
            end
            else if (cmd.age && age_do)
            begin
                cnt_reg[w] <= halve_up(cnt_reg[w]);
            end
        end
    end

    // Pick: hit way, else first free way, else first minimal way
    always_comb
    begin
        logic found;
        way_t min_way;
        cnt_t min_cnt;
        found   = 1'b0;
        used_next = '0;
        min_way = '0;
        min_cnt = cnt_reg[0];
        for (int w = 0; w < WAYS; w++)
        begin
            if (!found && cnt_reg[w] == '0)
            begin
                found     = 1'b1;
                used_next = way_t'(w);
            end
        end
        for (int w = 1; w < WAYS; w++)
        begin
            if (cnt_reg[w] < min_cnt)
            begin
                min_cnt = cnt_reg[w];
                min_way = way_t'(w);
            end
        end
        repl_next = 1'b0;
        if (hit_reg)
        begin
            used_next = hit_way_reg;
        end
        else if (!found)
        begin
            used_next = min_way;
            repl_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pick)
        begin
            used_reg <= used_next;
            repl_reg <= repl_next;
        end
    end

    // Commit: build the write-back row; a miss installs the tag with count one
    always_comb
    begin
        wr_row     = rd_data_reg;
        entry_next = cnt_reg[used_reg];
        for (int w = 0; w < WAYS; w++)
        begin
            wr_row[w*WAY_ROW_W +: CNT_W] = cnt_reg[w];
        end
        if (!hit_reg)
        begin
            entry_next = COUNT_ONE;
            wr_row[used_reg*WAY_ROW_W +: CNT_W]            = COUNT_ONE;
            wr_row[used_reg*WAY_ROW_W + CNT_W +: TAG_BITS] = tag_reg;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_hit_reg  <= hit_reg;
            out_way_reg  <= used_reg;
            out_cnt_reg  <= entry_next;
            out_hot_reg  <= (entry_next >= trig_reg);
            out_repl_reg <= repl_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = out_hit_reg;
    assign way_used    = 2'(out_way_reg);
    assign entry_count = out_cnt_reg;
    assign hot         = out_hot_reg;
    assign replaced    = out_repl_reg;

    `HLFU_ASSERT_NXT(a_commit_shows, clk, rst_n, cmd.commit, out_valid_reg)
    `HLFU_ASSERT_IMP(a_entry_nonzero, clk, rst_n, out_valid_reg, out_cnt_reg != '0)
    `HLFU_ASSERT_IMP(a_hit_no_evict, clk, rst_n, out_valid_reg && out_hit_reg, !out_repl_reg)

endmodule

`default_nettype wire
